// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/bpa_pkg.sv =====
package bpa_pkg;
    localparam int PAGE_CAP_DEF = 1024;
    localparam int RANKS_DEF    = 11;
    localparam int RANK_LIMIT   = 16;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_COUNT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
endpackage

// ===== rtl/core/bpa_stack_mem.sv =====
// Free stacks for all ranks, one synchronous memory, row = (rank-1)*PAGE_CAP + slot.
module bpa_stack_mem #(
    parameter int PAGE_CAP = 1024,
    parameter int RANKS    = 11,
    parameter int AW       = $clog2(PAGE_CAP * RANKS)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [$clog2(PAGE_CAP)-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [$clog2(PAGE_CAP)-1:0] rdata
);
    localparam int PW = $clog2(PAGE_CAP);
    logic [PW-1:0] mem [PAGE_CAP*RANKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/bpa_rank_mem.sv =====
// Per-page allocation rank, synchronous memory.
module bpa_rank_mem #(
    parameter int PAGE_CAP = 1024
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(PAGE_CAP)-1:0] waddr,
    input  logic [3:0]                  wdata,
    input  logic [$clog2(PAGE_CAP)-1:0] raddr,
    output logic [3:0]                  rdata
);
    logic [3:0] mem [PAGE_CAP];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/buddy_page_allocator.sv =====
// Channel     | Signals                                         | Direction
// command     | start, busy, action, rank, page                 | in (busy out)
// result      | done, status, block_page, rank_value, free_count| out
// config      | cfg_valid, cfg_ready, cfg_data                  | in (cfg_ready out)
// One command at a time. Count and rank-query-of-allocated need no search or scan;
// allocate searches upward for a non-empty stack, pops a block, splits it down to
// the requested rank and marks its pages; free marks its pages, then per merge
// level searches and compacts the buddy's rank stack. Free-page query rescans from
// each lower aligned rank, up to about 2^top pages. Cost is set by the single read
// port of each memory. After reset or a page_count write, a rebuild clears all
// PAGE_CAP rank entries and lays free blocks, at most one memory write a cycle;
// busy is high meanwhile. A config write waits while start is high. done is never
// stalled.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int PAGE_CAP = bpa_pkg::PAGE_CAP_DEF,
    parameter int RANKS    = bpa_pkg::RANKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [4:0]  rank,
    input  logic [9:0]  page,
    output logic        done,
    output logic [1:0]  status,
    output logic [9:0]  block_page,
    output logic [3:0]  rank_value,
    output logic [10:0] free_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);
    `include "assert_macros.svh"

    localparam int PW = $clog2(PAGE_CAP);
    localparam int CW = PW + 1;
    localparam int RW = $clog2(RANKS + 1) < 1 ? 1 : $clog2(RANKS + 1);
    localparam int AW = $clog2(PAGE_CAP * RANKS);
    localparam int SW = PW + 2;

    typedef enum logic [15:0] {
        S_INIT_CLR  = 16'h0001,
        S_INIT_LAY  = 16'h0002,
        S_IDLE      = 16'h0004,
        S_AL_FIND   = 16'h0008,
        S_AL_POPRD  = 16'h0010,
        S_AL_SPLIT  = 16'h0020,
        S_MARK      = 16'h0040,
        S_FR_RD     = 16'h0080,
        S_FR_CHK    = 16'h0100,
        S_FR_SRCH   = 16'h0200,
        S_FR_SHIFT  = 16'h0400,
        S_FR_PUSH   = 16'h0800,
        S_Q_RD      = 16'h1000,
        S_Q_CHK     = 16'h2000,
        S_Q_SCAN    = 16'h4000,
        S_DONE      = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] pcount_reg, pcount_next;
    logic [RW-1:0] top_reg, top_next;
    logic [CW-1:0] fill_reg [RANKS];
    logic [CW-1:0] fill_next [RANKS];

    // scratch registers
    logic [1:0]    act_reg, act_next;
    logic [4:0]    rq_reg, rq_next;       // requested rank
    logic [RW-1:0] r_reg, r_next;         // working rank
    logic [SW-1:0] pg_reg, pg_next;       // working page (wide for init walk)
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] idx_reg, idx_next;     // stack index / page counter
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]    mval_reg, mval_next;   // value to mark
    logic          mfree_reg, mfree_next; // marking done for a free: merge next
    logic [1:0]    st_reg, st_next;
    logic [9:0]    bp_reg, bp_next;
    logic [3:0]    rv_reg, rv_next;
    logic [10:0]   fc_reg, fc_next;
    logic          done_reg, done_next;

    // memories
    logic          s_we, r_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [PW-1:0] s_wdata, s_rdata;
    logic [PW-1:0] r_waddr, r_raddr;
    logic [3:0]    r_wdata, r_rdata;

    bpa_stack_mem #(.PAGE_CAP(PAGE_CAP), .RANKS(RANKS), .AW(AW)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    bpa_rank_mem #(.PAGE_CAP(PAGE_CAP)) u_rank (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    function automatic logic [AW-1:0] saddr(input logic [RW-1:0] r, input logic [CW-1:0] i);
        logic [AW+CW-1:0] a;
        a = (AW+CW)'(r - 1'b1) * (AW+CW)'(PAGE_CAP) + (AW+CW)'(i);
        return a[AW-1:0];
    endfunction

    function automatic logic [SW-1:0] rsize(input logic [RW-1:0] r);
        return SW'(1) << (r - 1'b1);
    endfunction

    function automatic logic [RW-1:0] calc_top(input logic [CW-1:0] pc);
        logic [RW-1:0] t;
        t = '0;
        for (int k = 0; k < RANKS && k < RANK_LIMIT; k++)
        begin
            if ((CW+1)'(1) << k <= (CW+1)'(pc))
            begin
                t = RW'(k + 1);
            end
        end
        return t;
    endfunction

    logic [CW-1:0] cfg_val;
    logic          cfg_we;
    logic [CW-1:0] fill_r;
    logic [SW-1:0] sz;
    logic [SW-1:0] buddy;

    // a pending command takes the idle slot ahead of a config write
    assign cfg_ready = (state_reg == S_IDLE) && !done_reg && !start;
    assign cfg_we    = cfg_valid && cfg_ready && (cfg_data != 11'd0);
    assign cfg_val   = (32'(cfg_data) > PAGE_CAP) ? CW'(PAGE_CAP) : CW'(cfg_data);
    assign busy      = (state_reg != S_IDLE) || done_reg;
    assign fill_r    = (r_reg >= RW'(1)) ? fill_reg[r_reg - 1'b1] : '0;
    assign sz        = rsize(r_reg);
    assign buddy     = pg_reg ^ sz;

    always_comb
    begin
        state_next = state_reg;
        pcount_next = pcount_reg;
        top_next = top_reg;
        for (int k = 0; k < RANKS; k++)
        begin
            fill_next[k] = fill_reg[k];
        end
        act_next = act_reg; rq_next = rq_reg; r_next = r_reg; pg_next = pg_reg;
        left_next = left_reg; idx_next = idx_reg; cnt_next = cnt_reg;
        mval_next = mval_reg; mfree_next = mfree_reg;
        st_next = st_reg; bp_next = bp_reg; rv_next = rv_reg; fc_next = fc_reg;
        done_next = 1'b0;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
        r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_raddr = '0;

        case (state_reg)
            S_INIT_CLR:
            begin
                r_we = 1'b1;
                r_waddr = idx_reg[PW-1:0];
                if (idx_reg == CW'(PAGE_CAP - 1))
                begin
                    top_next = calc_top(pcount_reg);
                    r_next = calc_top(pcount_reg);
                    pg_next = '0;
                    left_next = pcount_reg;
                    cnt_next = '0;
                    for (int k = 0; k < RANKS; k++)
                    begin
                        fill_next[k] = '0;
                    end
                    state_next = S_INIT_LAY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_INIT_LAY:
            begin
                // blocks of rank r: n = left/sz, pushed high to low so lowest on top
                if (r_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (SW'(left_reg) >= sz)
                begin
                    // count how many, then push in descending order
                    left_next = CW'(SW'(left_reg) - sz);
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (cnt_reg != '0)
                begin
                    s_we = 1'b1;
                    s_waddr = saddr(r_reg, fill_r);
                    s_wdata = PW'(pg_reg + SW'(cnt_reg - 1'b1) * sz);
                    fill_next[r_reg - 1'b1] = fill_r + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        pg_next = pg_reg + SW'(fill_r + 1'b1) * sz;
                        r_next = r_reg - 1'b1;
                    end
                end
                else
                begin
                    r_next = r_reg - 1'b1;
                end
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    pcount_next = cfg_val;
                    idx_next = '0;
                    state_next = S_INIT_CLR;
                end
                else if (start && !done_reg)
                begin
                    act_next = action;
                    rq_next = rank;
                    pg_next = SW'(page);
                    st_next = ST_OK; bp_next = '0; rv_next = '0; fc_next = '0;
                    r_raddr = page[PW-1:0];
                    case (action)
                        ACT_ALLOC:
                        begin
                            if (rank == 5'd0 || rank > 5'(RANK_LIMIT))
                            begin
                                st_next = ST_INVALID; state_next = S_DONE;
                            end
                            else if (rank > 5'(top_reg))
                            begin
                                st_next = ST_NOSPACE; state_next = S_DONE;
                            end
                            else
                            begin
                                r_next = RW'(rank);
                                state_next = S_AL_FIND;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (11'(page) >= 11'(pcount_reg))
                            begin
                                st_next = ST_INVALID; state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FR_RD;
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (11'(page) >= 11'(pcount_reg))
                            begin
                                st_next = ST_INVALID; state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_Q_RD;
                            end
                        end
                        default:
                        begin
                            if (rank == 5'd0 || rank > 5'(RANK_LIMIT))
                            begin
                                st_next = ST_INVALID;
                            end
                            else if (rank <= 5'(top_reg))
                            begin
                                fc_next = 11'(fill_reg[rank[RW-1:0] - 1'b1]);
                            end
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_AL_FIND:
            begin
                if (r_reg > top_reg)
                begin
                    st_next = ST_NOSPACE; state_next = S_DONE;
                end
                else if (fill_r == '0)
                begin
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    s_raddr = saddr(r_reg, fill_r - 1'b1);
                    fill_next[r_reg - 1'b1] = fill_r - 1'b1;
                    state_next = S_AL_POPRD;
                end
            end
            S_AL_POPRD:
            begin
                pg_next = SW'(s_rdata);
                state_next = S_AL_SPLIT;
            end
            S_AL_SPLIT:
            begin
                if (5'(r_reg) > rq_reg)
                begin
                    r_next = r_reg - 1'b1;
                    s_we = 1'b1;
                    s_waddr = saddr(r_reg - 1'b1, fill_reg[r_reg - 2'd2]);
                    s_wdata = PW'(pg_reg + rsize(r_reg - 1'b1));
                    if (fill_reg[r_reg - 2'd2] < CW'(PAGE_CAP))
                    begin
                        fill_next[r_reg - 2'd2] = fill_reg[r_reg - 2'd2] + 1'b1;
                    end
                    else
                    begin
                        s_we = 1'b0;
                    end
                end
                else
                begin
                    bp_next = 10'(pg_reg);
                    rv_next = 4'(rq_reg);
                    mval_next = 4'(rq_reg);
                    mfree_next = 1'b0;
                    idx_next = '0;
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                r_we = 1'b1;
                r_waddr = PW'(pg_reg + SW'(idx_reg));
                r_wdata = mval_reg;
                if (SW'(idx_reg) + 1'b1 >= sz)
                begin
                    state_next = mfree_reg ? S_FR_CHK : S_DONE;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (SW'(pg_reg + SW'(idx_reg)) >= SW'(PAGE_CAP))
                begin
                    r_we = 1'b0;
                end
            end
            S_FR_RD:
            begin
                r_next = RW'(r_rdata);
                if (r_rdata == 4'd0 || RW'(r_rdata) > top_reg ||
                    (pg_reg & (rsize(RW'(r_rdata)) - 1'b1)) != '0)
                begin
                    st_next = ST_INVALID; state_next = S_DONE;
                end
                else
                begin
                    mval_next = '0;
                    mfree_next = 1'b1;
                    idx_next = '0;
                    state_next = S_MARK;
                end
            end
            S_FR_CHK:
            begin
                // start searching for the buddy at r
                if (r_reg < top_reg && fill_r != '0)
                begin
                    idx_next = fill_r;
                    s_raddr = saddr(r_reg, fill_r - 1'b1);
                    state_next = S_FR_SRCH;
                end
                else
                begin
                    state_next = S_FR_PUSH;
                end
            end
            S_FR_SRCH:
            begin
                // s_rdata is entry idx_reg-1
                if (SW'(s_rdata) == buddy)
                begin
                    idx_next = idx_reg - 1'b1;
                    s_raddr = saddr(r_reg, idx_reg);
                    state_next = S_FR_SHIFT;
                end
                else if (idx_reg == CW'(1))
                begin
                    state_next = S_FR_PUSH;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    s_raddr = saddr(r_reg, idx_reg - 2'd2);
                end
            end
            S_FR_SHIFT:
            begin
                // move entry idx+1 to idx; s_rdata holds entry idx+1
                if (idx_reg + 1'b1 >= fill_r)
                begin
                    fill_next[r_reg - 1'b1] = fill_r - 1'b1;
                    pg_next = pg_reg & ~sz;
                    r_next = r_reg + 1'b1;
                    state_next = S_FR_CHK;
                end
                else
                begin
                    s_we = 1'b1;
                    s_waddr = saddr(r_reg, idx_reg);
                    s_wdata = s_rdata;
                    s_raddr = saddr(r_reg, idx_reg + 2'd2);
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FR_PUSH:
            begin
                if (fill_r < CW'(PAGE_CAP))
                begin
                    s_we = 1'b1;
                    s_waddr = saddr(r_reg, fill_r);
                    s_wdata = PW'(pg_reg);
                    fill_next[r_reg - 1'b1] = fill_r + 1'b1;
                end
                state_next = S_DONE;
            end
            S_Q_RD:
            begin
                if (r_rdata != 4'd0)
                begin
                    rv_next = r_rdata;
                    state_next = S_DONE;
                end
                else
                begin
                    r_next = top_reg;
                    state_next = S_Q_CHK;
                end
            end
            S_Q_CHK:
            begin
                if (r_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if ((pg_reg & (sz - 1'b1)) != '0 ||
                         pg_reg + sz > SW'(pcount_reg))
                begin
                    r_next = r_reg - 1'b1;
                end
                else
                begin
                    idx_next = '0;
                    r_raddr = PW'(pg_reg);
                    state_next = S_Q_SCAN;
                end
            end
            S_Q_SCAN:
            begin
                // r_rdata is page pg+idx
                if (r_rdata != 4'd0)
                begin
                    r_next = r_reg - 1'b1;
                    state_next = S_Q_CHK;
                end
                else if (SW'(idx_reg) + 1'b1 >= sz)
                begin
                    rv_next = 4'(r_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    r_raddr = PW'(pg_reg + SW'(idx_reg) + 1'b1);
                end
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            pcount_reg <= CW'(PAGE_CAP < 1024 ? PAGE_CAP : 1024);
            top_reg <= '0;
            for (int k = 0; k < RANKS; k++)
            begin
                fill_reg[k] <= '0;
            end
            idx_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pcount_reg <= pcount_next;
            top_reg <= top_next;
            for (int k = 0; k < RANKS; k++)
            begin
                fill_reg[k] <= fill_next[k];
            end
            idx_reg <= idx_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next; rq_reg <= rq_next; r_reg <= r_next; pg_reg <= pg_next;
        left_reg <= left_next; cnt_reg <= cnt_next;
        mval_reg <= mval_next; mfree_reg <= mfree_next;
        st_reg <= st_next; bp_reg <= bp_next; rv_reg <= rv_next; fc_reg <= fc_next;
    end

    assign done = done_reg;
    assign status = st_reg;
    assign block_page = bp_reg;
    assign rank_value = rv_reg;
    assign free_count = fc_reg;

    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `ASSERT_IMPLIES(a_busy_done, clk, rst_n, done, busy)
    `ASSERT_IMPLIES(a_top_range, clk, rst_n, state_reg == S_IDLE, top_reg <= RW'(RANKS))
    `ASSERT_IMPLIES(a_ok_alloc, clk, rst_n,
        done && act_reg == ACT_ALLOC && status == ST_OK, rank_value != 4'd0)
endmodule
